@@ rtl/sbd_pkg.sv @@
package sbd_pkg;

  localparam int FrameBytesDef   = 32;
  localparam int WireOverheadDef = 7;

  localparam logic [7:0] ByteEsc       = 8'hE0;
  localparam logic [7:0] ByteStart     = 8'hE2;
  localparam logic [7:0] ByteEnd       = 8'hE3;
  localparam logic [7:0] CmdNewerResp  = 8'hA1;
  localparam logic [7:0] CmdOlderResp  = 8'hF0;
  localparam int         MinFrameCount = 6;
  localparam int         MinAppLen     = 3;

  localparam logic [2:0] CfgClient    = 3'd0;
  localparam logic [2:0] CfgTarget    = 3'd1;
  localparam logic [2:0] CfgTargetEn  = 3'd2;
  localparam logic [2:0] CfgNewerPres = 3'd3;
  localparam logic [2:0] CfgOlderPres = 3'd4;
  localparam logic [2:0] CfgBcast     = 3'd5;
  localparam logic [2:0] CfgEntryId   = 3'd6;
  localparam logic [2:0] CfgCrcSeed   = 3'd7;

  typedef enum logic [1:0] {
    MODE_BYTE   = 2'd0,
    MODE_START  = 2'd1,
    MODE_EXPIRE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_PROBE = 2'd1,
    ACT_DONE  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_NEWER_WAIT = 2'd1,
    PH_OLDER_WAIT = 2'd2,
    PH_COMPLETE   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic       on_newer_link;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic       link_protocol;
    logic [7:0] probe_destination;
    logic [7:0] host_address;
    logic       frame_matched;
    logic [7:0] device_type;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  own_address;
    logic [7:0]  target_address;
    logic        target_enable;
    logic        newer_link_present;
    logic        older_link_present;
    logic [7:0]  broadcast_address;
    logic [15:0] wanted_entry_id;
    logic [15:0] crc_start_value;
  } cfg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ rtl/sbd_stream_if.sv @@
interface sbd_stream_if #(
  parameter int W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/serial_bus_discovery_deframer_core.sv @@
// Serial bus discovery deframer.
// in_s carries {mode, rx_byte, on_newer_link}; out_s carries one result per
// input transaction: {action, link_protocol, probe_destination, host_address,
// frame_matched, device_type}. Mode 3 transactions yield a result with no action.
// A transaction is queued when accepted and then moved from the queue into the
// back-end output register, which presents its result.
// Throughput: one transaction per cycle while the receiver takes results; framing,
// CRC-16 and header checks for a byte are combinational in the back end.
// Each link keeps only the first ten frame bytes in flops; later bytes, up to
// FRAME_BYTES in all, only feed the CRC and the byte count.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect on the
// next edge; issue them only while no transaction is in flight.
// Reset: all framing state cleared, phase idle, no board found, registers at
// their defaults.
// When the receiver stalls the output register holds, the queue fills and
// in_s.ready drops once the queue holds two transactions.
module serial_bus_discovery_deframer_core #(
  parameter int FRAME_BYTES   = sbd_pkg::FrameBytesDef,
  parameter int WIRE_OVERHEAD = sbd_pkg::WireOverheadDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sbd_stream_if.sink  in_s,
  sbd_stream_if.source out_s,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import sbd_pkg::*;

  cfg_t     cfg_q;
  logic     push, full, empty, pop;
  in_item_t push_item, pop_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_address        <= 8'd0;
      cfg_q.target_address     <= 8'd0;
      cfg_q.target_enable      <= 1'b0;
      cfg_q.newer_link_present <= 1'b1;
      cfg_q.older_link_present <= 1'b0;
      cfg_q.broadcast_address  <= 8'd255;
      cfg_q.wanted_entry_id    <= 16'd8;
      cfg_q.crc_start_value    <= 16'd4129;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgClient:    cfg_q.own_address        <= cfg_data_i[7:0];
        CfgTarget:    cfg_q.target_address     <= cfg_data_i[7:0];
        CfgTargetEn:  cfg_q.target_enable      <= cfg_data_i[0];
        CfgNewerPres: cfg_q.newer_link_present <= cfg_data_i[0];
        CfgOlderPres: cfg_q.older_link_present <= cfg_data_i[0];
        CfgBcast:     cfg_q.broadcast_address  <= cfg_data_i[7:0];
        CfgEntryId:   cfg_q.wanted_entry_id    <= cfg_data_i;
        CfgCrcSeed:   cfg_q.crc_start_value    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sbd_front u_front (
    .in_s,
    .push_o(push), .push_item_o(push_item), .full_i(full)
  );

  sbd_fifo #(.W($bits(in_item_t)), .DEPTH(2)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_item), .full_o(full), .empty_o(empty),
    .pop_i(pop), .pop_data_o(pop_item)
  );

  sbd_back #(.FRAME_BYTES(FRAME_BYTES), .WIRE_OVERHEAD(WIRE_OVERHEAD)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .empty_i(empty), .item_i(pop_item), .pop_o(pop), .out_s
  );
endmodule

@@ rtl/sbd_front.sv @@
// Front: accepts input transactions and pushes them unchanged into a small queue.
module sbd_front (
  sbd_stream_if.sink          in_s,
  output logic                push_o,
  output sbd_pkg::in_item_t   push_item_o,
  input  logic                full_i
);

  // Every mode, the unused one too, yields exactly one result downstream.
  assign in_s.ready  = !full_i;
  assign push_o      = in_s.valid && !full_i;
  assign push_item_o = in_s.data;
endmodule

@@ rtl/sbd_fifo.sv @@
module sbd_fifo #(
  parameter int W     = 11,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  output logic         full_o,
  output logic         empty_o,
  input  logic         pop_i,
  output logic [W-1:0] pop_data_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_d  = push_i ? inc(wr_q) : wr_q;
    rd_d  = pop_i ? inc(rd_q) : rd_q;
    cnt_d = cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  assign full_o     = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];
endmodule

@@ rtl/sbd_back.sv @@
// Back: framing, CRC, frame checks and discovery sequencing. One item per cycle while the output is not stalled.
module sbd_back #(
  parameter int FRAME_BYTES   = sbd_pkg::FrameBytesDef,
  parameter int WIRE_OVERHEAD = sbd_pkg::WireOverheadDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbd_pkg::cfg_t       cfg_i,
  input  logic                empty_i,
  input  sbd_pkg::in_item_t   item_i,
  output logic                pop_o,
  sbd_stream_if.source        out_s
);
  import sbd_pkg::*;

  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam int IW = $clog2(FRAME_BYTES);

  // Header bytes 0..9 are all that the checks read; kept in flops per link.
  logic [7:0]    hdr_q [2][10];
  logic [CW-1:0] cnt_q [2];
  logic [15:0]   crc_q [2];
  logic [1:0]    esc_q, open_q;
  phase_e        phase_q, phase_d;
  logic          found_q, found_d;
  logic [7:0]    faddr_q, faddr_d;

  logic      ovalid_q;
  out_item_t out_q, res;

  logic      take, li, newer, waiting, is_byte, data_byte, end_close, store_it;
  logic      match;
  logic [7:0] b [10];
  logic [7:0] app;
  logic [8:0] ds9;
  logic       next_newer, do_probe, do_clear;

  assign take  = !empty_i && (!ovalid_q || out_s.ready);
  assign pop_o = take;
  assign newer = item_i.on_newer_link;
  assign li    = !newer;

  always_comb begin
    for (int k = 0; k < 10; k++) b[k] = hdr_q[li][k];
    waiting = !found_q &&
              ((newer && phase_q == PH_NEWER_WAIT) || (!newer && phase_q == PH_OLDER_WAIT));
    is_byte   = (item_i.mode == MODE_BYTE) && waiting;
    end_close = is_byte && !esc_q[li] && item_i.rx_byte == ByteEnd && open_q[li];
    data_byte = is_byte && (esc_q[li] || (item_i.rx_byte != ByteEsc &&
                item_i.rx_byte != ByteStart && item_i.rx_byte != ByteEnd));
    store_it  = data_byte && (cnt_q[li] < CW'(FRAME_BYTES));
    app = b[1] - 8'(WIRE_OVERHEAD);
    match = (crc_q[li] == 16'h0) && (cnt_q[li] >= CW'(MinFrameCount)) &&
            (b[1] >= 8'(WIRE_OVERHEAD)) &&
            (b[0] == cfg_i.own_address || b[0] == cfg_i.broadcast_address) &&
            (app >= 8'(MinAppLen)) && (app >= 8'd6);
    if (newer) begin
      ds9 = 9'd6 + {1'b0, b[8]};
      match = match && b[3] == CmdNewerResp && b[5] == 8'h0 &&
              {b[6], b[7]} == cfg_i.wanted_entry_id && b[8] != 8'h0 &&
              {1'b0, app} >= ds9;
    end else begin
      ds9 = 9'd5 + {1'b0, b[7]};
      match = match && b[3] == CmdOlderResp && b[4] == 8'h1 &&
              {b[5], b[6]} == cfg_i.wanted_entry_id && b[7] != 8'h0 &&
              {1'b0, app} >= ds9;
    end
    match = match && (!cfg_i.target_enable || b[2] == cfg_i.target_address);
  end

  always_comb begin
    res        = '0;
    phase_d    = phase_q;
    found_d    = found_q;
    faddr_d    = faddr_q;
    do_probe   = 1'b0;
    do_clear   = 1'b0;
    next_newer = cfg_i.newer_link_present;
    unique case (item_i.mode)
      MODE_BYTE: begin
        if (end_close && match) begin
          found_d           = 1'b1;
          faddr_d           = b[2];
          res.link_protocol = newer;
          res.frame_matched = 1'b1;
          res.device_type   = newer ? b[9] : b[8];
        end
      end
      MODE_START: begin
        if (phase_q == PH_IDLE && (cfg_i.newer_link_present || cfg_i.older_link_present))
          do_probe = 1'b1;
      end
      MODE_EXPIRE: begin
        if (phase_q == PH_NEWER_WAIT || phase_q == PH_OLDER_WAIT) begin
          if (found_q) begin
            res.action        = ACT_DONE;
            res.link_protocol = (phase_q != PH_OLDER_WAIT);
            phase_d           = PH_COMPLETE;
          end else begin
            do_clear = 1'b1;
            do_probe = 1'b1;
            if (cfg_i.newer_link_present && cfg_i.older_link_present)
              next_newer = (phase_q != PH_NEWER_WAIT);
          end
        end
      end
      default: ;
    endcase
    if (do_probe) begin
      phase_d               = next_newer ? PH_NEWER_WAIT : PH_OLDER_WAIT;
      res.action            = ACT_PROBE;
      res.link_protocol     = next_newer;
      res.probe_destination = cfg_i.target_enable ? cfg_i.target_address
                                                  : cfg_i.broadcast_address;
    end
    res.host_address = faddr_d;
    if (res.action == ACT_NONE && !res.frame_matched) res.host_address = faddr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      found_q  <= 1'b0;
      faddr_q  <= '0;
      esc_q    <= '0;
      open_q   <= '0;
      ovalid_q <= 1'b0;
      for (int l = 0; l < 2; l++) begin
        cnt_q[l] <= '0;
        crc_q[l] <= '0;
        for (int k = 0; k < 10; k++) hdr_q[l][k] <= '0;
      end
    end else begin
      if (take) ovalid_q <= 1'b1;
      else if (out_s.ready) ovalid_q <= 1'b0;
      if (take) begin
        phase_q  <= phase_d;
        found_q  <= found_d;
        faddr_q  <= faddr_d;
        if (do_clear) begin
          esc_q  <= '0;
          open_q <= '0;
          for (int l = 0; l < 2; l++) begin
            cnt_q[l] <= '0;
            crc_q[l] <= '0;
            for (int k = 0; k < 10; k++) hdr_q[l][k] <= '0;
          end
        end else if (is_byte) begin
          if (!esc_q[li] && item_i.rx_byte == ByteEsc) begin
            esc_q[li] <= 1'b1;
          end else if (!esc_q[li] && item_i.rx_byte == ByteStart) begin
            cnt_q[li]  <= '0;
            crc_q[li]  <= cfg_i.crc_start_value;
            open_q[li] <= 1'b1;
          end else if (!esc_q[li] && item_i.rx_byte == ByteEnd) begin
            if (open_q[li]) begin
              open_q[li] <= 1'b0;
              cnt_q[li]  <= '0;
            end
          end else begin
            esc_q[li] <= 1'b0;
            if (store_it) begin
              for (int k = 0; k < 10; k++)
                if (cnt_q[li][IW-1:0] == IW'(k) && cnt_q[li] < CW'(10))
                  hdr_q[li][k] <= item_i.rx_byte;
              cnt_q[li] <= cnt_q[li] + 1'b1;
              crc_q[li] <= crc_byte(crc_q[li], item_i.rx_byte);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_q <= res;
  end

  assign out_s.valid = ovalid_q;
  assign out_s.data  = out_q;
endmodule
